// ----- sv/sss_pkg.sv -----
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants for the small set store: request and result
// payloads, status codes, and the controller/datapath command interface.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // Source of the result position field
  typedef enum logic [1:0] {
    POS_ZERO  = 2'd0,
    POS_COUNT = 2'd1,
    POS_IDX   = 2'd2,
    POS_MARK  = 2'd3
  } pos_sel_t;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] position;
    logic [4:0] cardinality;
  } out_rsp_t;

  // Controller -> datapath
  typedef struct packed {
    logic     start;     // latch request value, clear scan index
    logic     rd_en;     // memory read
    logic     rd_next;   // read at index + 1 instead of index
    logic     idx_inc;
    logic     mark;      // remember index of the first match
    logic     wr_ins;    // append value at count
    logic     wr_shift;  // move read data down to index
    logic     cnt_inc;
    logic     cnt_dec;
    logic     load_out;  // load result register
    status_t  res_status;
    pos_sel_t res_pos;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic full;       // count at effective capacity
    logic at_end;     // scan index reached count
    logic shift_end;  // index + 1 reached count
    logic match;      // read data equals request value
  } sts_t;

endpackage

// ----- sv/sss_datapath.sv -----
// ----------------------------------------------------------------------------
// sss_datapath
// Entry memory, element count, capacity register, scan index and the
// registered result.
// ----------------------------------------------------------------------------
module sss_datapath #(
  parameter int unsigned DEPTH = sss_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sss_pkg::cmd_t             cmd,
  output sss_pkg::sts_t             sts,
  input  sss_pkg::in_req_t          in_req,
  output sss_pkg::out_rsp_t         out_rsp,
  input  logic                      cfg_we,
  input  logic [sss_pkg::CAP_W-1:0] cfg_data
);
  import sss_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = (CW > CAP_W) ? CW : CAP_W;

  logic [31:0]       mem [DEPTH];
  logic [31:0]       rdata_r;
  logic [31:0]       val_r;
  logic [CW-1:0]     idx_r;
  logic [CW-1:0]     pos_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic [KW-1:0]     cap_k;
  logic [KW-1:0]     eff_cap;
  logic [CW-1:0]     idx_p1;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [31:0]       wr_data;
  logic [3:0]        res_pos;
  out_rsp_t          out_rsp_r;

  assign cap_k   = KW'(cap_r);
  assign eff_cap = (cap_k > KW'(DEPTH)) ? KW'(DEPTH) : cap_k;
  assign idx_p1  = idx_r + CW'(1);

  assign sts.full      = KW'(count_r) >= eff_cap;
  assign sts.at_end    = idx_r >= count_r;
  assign sts.shift_end = idx_p1 >= count_r;
  assign sts.match     = rdata_r == val_r;

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign rd_addr = cmd.rd_next ? AW'(idx_p1) : AW'(idx_r);
  assign wr_addr = cmd.wr_ins ? AW'(count_r) : AW'(idx_r);
  assign wr_data = cmd.wr_ins ? val_r : rdata_r;

  always_comb begin
    case (cmd.res_pos)
      POS_COUNT: res_pos = 4'(count_r);
      POS_IDX:   res_pos = 4'(idx_r);
      POS_MARK:  res_pos = 4'(pos_r);
      default:   res_pos = 4'd0;
    endcase
  end

  // Entry store
  always_ff @(posedge clk) begin
    if (cmd.wr_ins || cmd.wr_shift) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      val_r <= in_req.value;
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_p1;
    end
    if (cmd.mark) begin
      pos_r <= idx_r;
    end
    if (cmd.load_out) begin
      out_rsp_r.status      <= cmd.res_status;
      out_rsp_r.position    <= res_pos;
      out_rsp_r.cardinality <= 5'(count_nxt);
    end
  end

  assign out_rsp = out_rsp_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above store depth");

  a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !sts.full)
    else $error("insert committed at capacity");

  a_shift_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_shift |-> $past(cmd.rd_en && cmd.rd_next))
    else $error("shift write without preceding next-entry read");

endmodule

// ----- sv/sss_ctrl.sv -----
// ----------------------------------------------------------------------------
// sss_ctrl
// Request sequencer: insert, linear scan for lookup/remove, shift-down
// after a remove hit, and the result valid flag.
// ----------------------------------------------------------------------------
module sss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sss_pkg::action_t in_action,
  output logic             out_valid,
  input  logic             out_stall,
  output sss_pkg::cmd_t    cmd,
  input  sss_pkg::sts_t    sts
);
  import sss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

  state_t  state_r, state_nxt;
  action_t act_r, act_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    cmd            = '0;
    cmd.res_status = ST_OK;
    cmd.res_pos    = POS_ZERO;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          act_nxt   = in_action;
          if (in_action == ACT_REMOVE || in_action == ACT_LOOKUP) begin
            state_nxt = S_SCAN_RD;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
          if (act_r == ACT_INSERT) begin
            if (sts.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.wr_ins  = 1'b1;
              cmd.cnt_inc = 1'b1;
              cmd.res_pos = POS_COUNT;
            end
          end
        end
      end
      S_SCAN_RD: begin
        if (sts.at_end) begin
          if (out_free) begin
            cmd.load_out   = 1'b1;
            cmd.res_status = ST_MISS;
            state_nxt      = S_IDLE;
          end
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts.match) begin
          cmd.mark = 1'b1;
          if (act_r == ACT_LOOKUP) begin
            if (out_free) begin
              cmd.load_out = 1'b1;
              cmd.res_pos  = POS_IDX;
              state_nxt    = S_IDLE;
            end
          end else begin
            state_nxt = S_SHIFT_RD;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts.shift_end) begin
          if (out_free) begin
            cmd.cnt_dec  = 1'b1;
            cmd.load_out = 1'b1;
            cmd.res_pos  = POS_MARK;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_nxt   = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= ACT_INSERT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free)
    else $error("result register loaded while a result is pending");

  a_one_mem_access: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_ins, cmd.wr_shift, cmd.rd_en}))
    else $error("more than one memory access in a cycle");

  a_dec_at_shift_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> (cmd.load_out && state_r == S_SHIFT_RD && sts.shift_end))
    else $error("count decremented outside the end of a remove");

  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not presented after completion");

endmodule

// ----- sv/small_set_store.sv -----
// ----------------------------------------------------------------------------
// small_set_store
// Unsorted set of signed 32-bit values with compaction on remove.
// ----------------------------------------------------------------------------
// Each request inserts, removes or looks up one value and yields exactly one
// result with a status, a position and the cardinality after the request.
// The block takes one request at a time. Entries live in a single-port-read,
// single-port-write memory, and every entry visit is a read step followed by a
// compare or write step, so timing depends on where the value sits. Insert
// and the unused action need no scan; lookups and removes scan up to the
// first match, or to the count on a miss, and a remove hit then moves each
// later entry down one place. The result register lets a new request be
// accepted while the previous result waits on out_stall; completion of the
// new request then holds until that result is taken. There is no clearing
// pass after reset: only entries below the count are ever read, and each was
// written by an insert or a shift-down. Capacity is written through the cfg
// port while the block is idle; values above DEPTH act as DEPTH, zero makes
// every insert report full.
// ----------------------------------------------------------------------------
module small_set_store #(
  parameter int unsigned DEPTH = sss_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  sss_pkg::in_req_t          in_req,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output sss_pkg::out_rsp_t         out_rsp,
  // capacity register write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sss_pkg::CAP_W-1:0] cfg_data
);
  import sss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Capacity writes are always taken; the user must send them only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  sss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_req.action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  sss_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_req   (in_req),
    .out_rsp  (out_rsp),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data)
  );

endmodule

// ----- tb/small_set_store_test.sv -----
// ----------------------------------------------------------------------------
// small_set_store_test
// Self-checking bench for the small set store. A driver feeds requests from
// a pending queue, and a scoreboard predicts each result from its own copy of
// the set. A monitor compares every result field by field with the oldest
// prediction. Both channels idle in random bursts. Capacity is rewritten
// between phases, covering zero, one, the full depth and values above it.
// ----------------------------------------------------------------------------
module small_set_store_test;
  import sss_pkg::*;

  localparam int unsigned     SLOTS       = DEPTH_DEF;
  localparam logic [1:0]      ACT_SPARE   = 2'd3;   // unused action code
  localparam int              SETTLE_CYC  = 40;     // exceeds the worst-case remove
  localparam int              QUIET_LIMIT = 2000;   // cycles without any handshake
  localparam int              PHASE_REQS  = 103;
  localparam logic [31:0]     INT_MIN     = 32'h8000_0000;
  localparam logic [31:0]     INT_MAX     = 32'h7fff_ffff;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_req_t          in_req = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_rsp_t         out_rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = CAP_RESET;

  small_set_store dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // requests waiting to be driven, results still owed by the block
  in_req_t     pending [$];
  out_rsp_t    results_due [$];

  // shadow of the set: stored values, element count, capacity register
  logic [31:0]      members [SLOTS];
  int unsigned      member_count = 0;
  logic [CAP_W-1:0] capacity_now = CAP_RESET;

  int          mismatches = 0;
  bit          quiet_tail = 1'b0;  // no idling in the final phase
  int          in_gap = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  logic [31:0] pool [8];           // values reused so hits and duplicates occur

  // Apply one request to the shadow set and return the result it must give.
  function automatic out_rsp_t apply_request(in_req_t r);
    out_rsp_t    rsp;
    int          hit;
    int unsigned k;
    int unsigned room;
    rsp  = '0;
    hit  = -1;
    room = (capacity_now > SLOTS) ? SLOTS : capacity_now;
    // first match among stored elements only
    for (k = 0; k < member_count; k++)
      if (hit < 0 && members[k] == r.value) hit = k;
    case (r.action)
      ACT_INSERT: begin
        if (member_count >= room) begin
          rsp.status = ST_FULL;          // dropped, position stays 0
        end else begin
          members[member_count] = r.value;
          rsp.position = 4'(member_count);
          member_count++;
        end
      end
      ACT_REMOVE: begin
        if (hit < 0) begin
          rsp.status = ST_MISS;
        end else begin
          // close the gap: later entries move down one place
          for (k = hit; k + 1 < member_count; k++) members[k] = members[k + 1];
          member_count--;
          members[member_count] = '0;
          rsp.position = 4'(hit);
        end
      end
      ACT_LOOKUP: begin
        if (hit < 0) rsp.status = ST_MISS;
        else rsp.position = 4'(hit);
      end
      default: ;                         // spare action: state untouched
    endcase
    rsp.cardinality = 5'(member_count);
    return rsp;
  endfunction

  function automatic in_req_t make_req(logic [1:0] act, logic [31:0] v);
    return in_req_t'({act, v});
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 6) == 0) return $urandom;
    return pool[$urandom_range(0, 7)];
  endfunction

  function automatic logic [31:0] fresh_value();
    case ($urandom_range(0, 9))
      0: return INT_MIN;
      1: return INT_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Driver: hands out pending requests, predicts each one as it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) results_due.push_back(apply_request(in_req));
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          in_req   <= pending.pop_front();
          in_valid <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic flag(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    mismatches++;
  endtask

  // Monitor: checks results, tracks capacity writes, drives out_stall,
  // and runs the watchdog.
  always @(posedge clk) begin
    out_rsp_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0h", $time, out_rsp);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (out_rsp.status !== want.status)
            flag("status", 32'(want.status), 32'(out_rsp.status));
          if (out_rsp.position !== want.position)
            flag("position", 32'(want.position), 32'(out_rsp.position));
          if (out_rsp.cardinality !== want.cardinality)
            flag("cardinality", 32'(want.cardinality), 32'(out_rsp.cardinality));
        end
      end
      if (cfg_valid && cfg_ready) capacity_now <= cfg_data;

      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end

      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Let every request drain, give the block its worst latency, then write
  // the capacity. Returns at a falling edge so queue updates stay clean.
  task automatic set_capacity(logic [CAP_W-1:0] cap);
    while (pending.size() != 0 || in_valid || results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_data  <= cap;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_random(int n);
    int         k;
    int         roll;
    logic [1:0] act;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40)      act = ACT_INSERT;
      else if (roll < 70) act = ACT_REMOVE;
      else if (roll < 95) act = ACT_LOOKUP;
      else                act = ACT_SPARE;
      pending.push_back(make_req(act, pick_value()));
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps [10];
    int               p;
    caps = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd7, 5'd17, 5'd2, 5'd0, 5'd0, 5'd16};
    caps[7] = 5'($urandom_range(0, 31));
    caps[8] = 5'($urandom_range(0, 31));
    foreach (pool[i]) pool[i] = fresh_value();

    // empty set at reset capacity: misses and the spare action
    pending.push_back(make_req(ACT_LOOKUP, 32'd5));
    pending.push_back(make_req(ACT_REMOVE, 32'd5));
    pending.push_back(make_req(ACT_SPARE, 32'd7));
    // extremes, a duplicate, first-match lookup, removes from middle/middle/first
    pending.push_back(make_req(ACT_INSERT, INT_MIN));
    pending.push_back(make_req(ACT_INSERT, INT_MAX));
    pending.push_back(make_req(ACT_INSERT, '0));
    pending.push_back(make_req(ACT_INSERT, '1));
    pending.push_back(make_req(ACT_INSERT, INT_MAX));
    pending.push_back(make_req(ACT_LOOKUP, INT_MAX));
    pending.push_back(make_req(ACT_REMOVE, INT_MAX));
    pending.push_back(make_req(ACT_LOOKUP, INT_MAX));
    pending.push_back(make_req(ACT_REMOVE, '1));
    pending.push_back(make_req(ACT_REMOVE, INT_MIN));
    pending.push_back(make_req(ACT_LOOKUP, 32'd1));
    pending.push_back(make_req(ACT_SPARE, INT_MIN));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // set holds {0, MAX}: capacity two is already reached
    set_capacity(5'd2);
    pending.push_back(make_req(ACT_INSERT, 32'd3));
    // capacity lowered below the count: stored entries stay, inserts drop
    set_capacity(5'd1);
    pending.push_back(make_req(ACT_INSERT, 32'd4));
    pending.push_back(make_req(ACT_REMOVE, '0));
    pending.push_back(make_req(ACT_INSERT, 32'd4));
    pending.push_back(make_req(ACT_REMOVE, INT_MAX));
    pending.push_back(make_req(ACT_INSERT, 32'd42));
    pending.push_back(make_req(ACT_INSERT, 32'd43));
    // zero capacity: every insert is dropped
    set_capacity(5'd0);
    pending.push_back(make_req(ACT_INSERT, 32'd44));
    pending.push_back(make_req(ACT_REMOVE, 32'd42));
    pending.push_back(make_req(ACT_INSERT, 32'd44));

    for (p = 0; p < 10; p++) begin
      set_capacity(caps[p]);
      // rotate part of the value pool; old values may still sit in the set
      pool[$urandom_range(0, 7)] = fresh_value();
      pool[$urandom_range(0, 7)] = fresh_value();
      if (p == 9) quiet_tail = 1'b1;
      queue_random(PHASE_REQS);
    end

    while (pending.size() != 0 || in_valid || results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    mismatches += results_due.size();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
